// ----- src/hdp_pkg.sv -----
// hdp_pkg: shared types, register indexes and constants of the drive-to-point controller
// no dependencies; used by the channel interfaces, controller, datapath and top level
package hdp_pkg;

  localparam int POS_W    = 24;
  localparam int HEAD_W   = 16;
  localparam int TIME_W   = 32;
  localparam int VOLT_W   = 15;
  localparam int MV_W     = 14;
  localparam int RAD_W    = 23;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W   = 5;
  localparam int SQRT_STEPS = 25;
  localparam int ATAN_N   = 24;

  localparam logic [MODE_W-1:0] LIMIT_FRONT = 2'd1;
  localparam logic [MODE_W-1:0] LIMIT_BACK  = 2'd2;

  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_X    = 3'd0,
    CFG_TARGET_Y    = 3'd1,
    CFG_MAX_VOLTAGE = 3'd2,
    CFG_MIN_VOLTAGE = 3'd3,
    CFG_STOP_RADIUS = 3'd4,
    CFG_LIMIT_MODE  = 3'd5,
    CFG_TIMEOUT     = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_SQRT, ST_ERR, ST_MUL_P, ST_MUL_I,
    ST_MUL_D, ST_VOLT, ST_HEAD, ST_VEC_INIT, ST_VEC, ST_ROT_INIT, ST_ROT, ST_FIN
  } hdp_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_DIFF, OP_SQX, OP_SQY, OP_SQRT, OP_ERR, OP_MUL_P,
    OP_MUL_I, OP_MUL_D, OP_VOLT, OP_HEAD, OP_VEC_INIT, OP_VEC, OP_ROT_INIT,
    OP_ROT, OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] step;
  } hdp_cmd_t;

  typedef struct packed {
    logic frozen;
    logic out_free;
  } hdp_stat_t;

endpackage

// ----- src/hdp_if.sv -----
// hdp_in_if / hdp_out_if: valid-ready channels for position samples and drive results
// depends on hdp_pkg for field widths
interface hdp_in_if import hdp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [HEAD_W-1:0]        heading;
  logic [TIME_W-1:0]        elapsed_us;
  logic                     front_touch;
  logic                     back_pressed;

  modport source (output valid, pos_x, pos_y, heading, elapsed_us, front_touch,
                  back_pressed, input ready);
  modport sink (input valid, pos_x, pos_y, heading, elapsed_us, front_touch,
                back_pressed, output ready);
endinterface

interface hdp_out_if import hdp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VOLT_W-1:0] positive_diag_mv;
  logic signed [VOLT_W-1:0] negative_diag_mv;
  logic                     grip_front;
  logic                     grip_back;
  logic                     done_res;

  modport source (output valid, positive_diag_mv, negative_diag_mv, grip_front,
                  grip_back, done_res, input ready);
  modport sink (input valid, positive_diag_mv, negative_diag_mv, grip_front,
                grip_back, done_res, output ready);
endinterface

// ----- src/hdp_ctrl.sv -----
// hdp_ctrl: sequencer that steps the datapath through one sample
// depends on hdp_pkg (state, command and status types)
module hdp_ctrl import hdp_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  hdp_stat_t stat,
  output hdp_cmd_t  cmd
);

  localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(SQRT_STEPS - 1);
  localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);

  hdp_state_t        state, state_next;
  logic [STEP_W-1:0] step;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DIFF;
      ST_DIFF:     state_next = stat.frozen ? ST_FIN : ST_SQX;
      ST_SQX:      state_next = ST_SQY;
      ST_SQY:      state_next = ST_SQRT;
      ST_SQRT:     if (step == SQRT_LAST) state_next = ST_ERR;
      ST_ERR:      state_next = ST_MUL_P;
      ST_MUL_P:    state_next = ST_MUL_I;
      ST_MUL_I:    state_next = ST_MUL_D;
      ST_MUL_D:    state_next = ST_VOLT;
      ST_VOLT:     state_next = ST_HEAD;
      ST_HEAD:     state_next = ST_VEC_INIT;
      ST_VEC_INIT: state_next = ST_VEC;
      ST_VEC:      if (step == CORDIC_LAST) state_next = ST_ROT_INIT;
      ST_ROT_INIT: state_next = ST_ROT;
      ST_ROT:      if (step == CORDIC_LAST) state_next = ST_FIN;
      ST_FIN:      if (stat.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.step = step;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_TAKE : OP_NONE;
      end
      ST_DIFF:     cmd.op = OP_DIFF;
      ST_SQX:      cmd.op = OP_SQX;
      ST_SQY:      cmd.op = OP_SQY;
      ST_SQRT:     cmd.op = OP_SQRT;
      ST_ERR:      cmd.op = OP_ERR;
      ST_MUL_P:    cmd.op = OP_MUL_P;
      ST_MUL_I:    cmd.op = OP_MUL_I;
      ST_MUL_D:    cmd.op = OP_MUL_D;
      ST_VOLT:     cmd.op = OP_VOLT;
      ST_HEAD:     cmd.op = OP_HEAD;
      ST_VEC_INIT: cmd.op = OP_VEC_INIT;
      ST_VEC:      cmd.op = OP_VEC;
      ST_ROT_INIT: cmd.op = OP_ROT_INIT;
      ST_ROT:      cmd.op = OP_ROT;
      ST_FIN:      cmd.op = OP_FIN;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_SQRT || state == ST_VEC || state == ST_ROT) && state_next == state)
        step <= step + STEP_W'(1);
      else
        step <= '0;
    end
  end

endmodule

// ----- src/hdp_dp.sv -----
// hdp_dp: datapath with registers, isqrt, shared multiplier, shared cordic and result register
// depends on hdp_pkg; driven by hdp_ctrl commands
module hdp_dp import hdp_pkg::*; #(
  parameter int unsigned SETTLE_US = 250000
) (
  input  logic                     clk,
  input  logic                     rst,
  input  hdp_cmd_t                 cmd,
  output hdp_stat_t                stat,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic [HEAD_W-1:0]        heading,
  input  logic [TIME_W-1:0]        elapsed_us,
  input  logic                     front_touch,
  input  logic                     back_pressed,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VOLT_W-1:0] positive_diag_mv,
  output logic signed [VOLT_W-1:0] negative_diag_mv,
  output logic                     grip_front,
  output logic                     grip_back,
  output logic                     done_res
);

  localparam int CW = 56;
  localparam int ZW = 34;
  localparam int ERR_FLOOR  = 1280;
  localparam int NEAR_LIMIT = 1024;
  localparam int RAMP_STEP  = 32;
  localparam int H_RECIP    = (2**28 + 29) / 45;
  localparam logic [31:0] QUARTER = 32'h2000_0000;
  localparam logic [23:0] GAIN_Q24 = 24'd10187969;

  function automatic logic signed [CW-1:0] tdiv(input logic signed [CW-1:0] v,
                                                 input logic [STEP_W-1:0] sh);
    logic signed [CW-1:0] q;
    logic [CW-1:0]        lost;
    q    = v >>> sh;
    lost = v & ~({CW{1'b1}} << sh);
    if (v[CW-1] && lost != '0) q = q + CW'(1);
    return q;
  endfunction

  function automatic logic signed [CW-1:0] rnd24(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] a;
    if (!v[CW-1]) begin
      a = (v + CW'(2**23)) >>> 24;
    end else begin
      a = ((-v) + CW'(2**23)) >>> 24;
      a = -a;
    end
    return a;
  endfunction

  // config
  logic signed [POS_W-1:0] target_x, target_y;
  logic [MV_W-1:0]         max_voltage, min_voltage;
  logic [RAD_W-1:0]        stop_radius;
  logic [MODE_W-1:0]       limit_mode;
  logic [TIME_W-1:0]       timeout_us;

  // sample
  logic signed [POS_W-1:0] px, py;
  logic [HEAD_W-1:0]       hd;
  logic [TIME_W-1:0]       t;
  logic                    ft, bp;

  // session state
  logic signed [25:0] previous_error;
  logic signed [39:0] integral_sum;
  logic [23:0]        ramp_level;
  logic               first_sample, target_reached, session_over;
  logic [TIME_W-1:0]  reached_time;

  // working registers
  logic signed [24:0] dx, dy;
  logic [49:0]        radicand;
  logic [25:0]        rem;
  logic [24:0]        root;
  logic signed [25:0] e_reg, sv_reg;
  logic signed [26:0] d_reg;
  logic signed [CW-1:0] acc;
  logic [MV_W-1:0]    m_reg;
  logic [21:0]        hx;
  logic [32:0]        hq;
  logic [31:0]        h32;
  logic               zero_vec, rneg;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;

  logic lf, lb;
  assign lf = (limit_mode == LIMIT_FRONT);
  assign lb = (limit_mode == LIMIT_BACK);

  // isqrt step
  logic [27:0] rem_sh, trial;
  always_comb begin
    rem_sh = {rem, radicand[49:48]};
    trial  = {1'b0, root, 2'b01};
  end

  // error and pid terms
  logic signed [25:0] e_raw, e_f, prev_use, sv;
  logic [25:0]        mag_e;
  logic signed [40:0] isum;
  logic signed [39:0] int_next;
  logic [34:0]        clr_lhs;
  logic               int_clr;
  logic signed [26:0] d_val;
  logic [24:0]        ramp_sum;
  logic [22:0]        radius;
  always_comb begin
    radius   = (lf || lb) ? '0 : stop_radius;
    e_raw    = $signed({1'b0, root}) - $signed({3'b0, radius});
    prev_use = first_sample ? e_raw : previous_error;
    e_f      = ((lf || lb) && e_raw < $signed(26'(ERR_FLOOR))) ? $signed(26'(ERR_FLOOR)) : e_raw;
    mag_e    = e_f[25] ? 26'(-e_f) : 26'(e_f);
    if (mag_e < {2'b0, ramp_level}) sv = e_f;
    else if (e_f[25]) sv = -$signed({2'b0, ramp_level});
    else sv = $signed({2'b0, ramp_level});
    isum = $signed({integral_sum[39], integral_sum}) + $signed({{15{e_f[25]}}, e_f});
    if (isum[40] != isum[39]) int_next = isum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    else int_next = isum[39:0];
    clr_lhs = 35'(mag_e) * 35'(375);
    int_clr = (e_f == '0) || (e_f > $signed(26'(256))) ||
              (clr_lhs > 35'({max_voltage, 3'b000}));
    d_val    = $signed({e_f[25], e_f}) - $signed({prev_use[25], prev_use});
    ramp_sum = {1'b0, ramp_level} + 25'(RAMP_STEP);
  end

  // shared multiplier
  logic signed [40:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [58:0] prod;
  always_comb begin
    case (cmd.op)
      OP_MUL_P: begin
        mul_a = $signed({{15{sv_reg[25]}}, sv_reg});
        mul_b = 18'sd100000;
      end
      OP_MUL_I: begin
        mul_a = $signed({integral_sum[39], integral_sum});
        mul_b = 18'sd5000;
      end
      default: begin
        mul_a = $signed({{14{d_reg[26]}}, d_reg});
        mul_b = 18'sd100;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // voltage magnitude
  logic signed [CW-1:0] acc_adj, v;
  logic [CW-1:0]        mag_v;
  logic [MV_W-1:0]      mv, mm;
  always_comb begin
    acc_adj = acc + (acc[CW-1] ? CW'(255) : CW'(0));
    v       = acc_adj >>> 8;
    mag_v   = v[CW-1] ? CW'(-v) : CW'(v);
    if (e_reg == '0) mv = '0;
    else if (mag_v < CW'(max_voltage)) mv = mag_v[MV_W-1:0];
    else mv = max_voltage;
    mm = (mv != '0 && mv < min_voltage) ? min_voltage : mv;
  end

  // cordic step, vectoring or rotation
  logic signed [CW-1:0] xs, ys;
  logic [31:0]          atan;
  logic                 br;
  always_comb begin
    xs   = tdiv(cx, cmd.step);
    ys   = tdiv(cy, cmd.step);
    atan = ATAN_TAB[cmd.step];
    br   = (cmd.op == OP_VEC) ? cy[CW-1] : ~cz[ZW-1];
  end

  // rotation setup
  logic [31:0] ang, ang_f;
  logic        fold;
  always_comb begin
    ang   = zero_vec ? QUARTER : cz[31:0] - h32 + QUARTER;
    ang_f = ang - 32'h4000_0000;
    fold  = ~ang_f[31];
  end

  // finish: rounding, clamping and session end
  logic signed [CW-1:0] rx, ry, ms, cxl, cyl;
  logic signed [VOLT_W-1:0] cv, snv;
  logic gf, gb, touch, tmo, near, cond, ended;
  logic [TIME_W-1:0] rt_new;
  logic [25:0] mag_er;
  always_comb begin
    rx = rnd24(cx);
    ry = rnd24(cy);
    ms = $signed(CW'(m_reg));
    cxl = (rx > ms) ? ms : ((rx < -ms) ? -ms : rx);
    cyl = (ry > ms) ? ms : ((ry < -ms) ? -ms : ry);
    cv  = rneg ? VOLT_W'(-cxl) : VOLT_W'(cxl);
    snv = rneg ? VOLT_W'(-cyl) : VOLT_W'(cyl);
    gf     = lf && ft;
    gb     = !gf && lb && bp;
    touch  = gf || gb;
    tmo    = t > timeout_us;
    mag_er = e_reg[25] ? 26'(-e_reg) : 26'(e_reg);
    near   = mag_er <= 26'(NEAR_LIMIT);
    cond   = near || target_reached || tmo || touch;
    rt_new = target_reached ? reached_time : t;
    ended  = touch || (cond && ((t - rt_new) >= TIME_W'(SETTLE_US) || tmo));
  end

  logic commit;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.frozen   = session_over;
  assign commit        = (cmd.op == OP_FIN) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x    <= '0;
      target_y    <= '0;
      max_voltage <= MV_W'(12000);
      min_voltage <= '0;
      stop_radius <= '0;
      limit_mode  <= '0;
      timeout_us  <= TIME_W'(5000000);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TARGET_X:    target_x    <= cfg_data[POS_W-1:0];
        CFG_TARGET_Y:    target_y    <= cfg_data[POS_W-1:0];
        CFG_MAX_VOLTAGE: max_voltage <= cfg_data[MV_W-1:0];
        CFG_MIN_VOLTAGE: min_voltage <= cfg_data[MV_W-1:0];
        CFG_STOP_RADIUS: stop_radius <= cfg_data[RAD_W-1:0];
        CFG_LIMIT_MODE:  limit_mode  <= cfg_data[MODE_W-1:0];
        CFG_TIMEOUT:     timeout_us  <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
      ramp_level     <= '0;
      first_sample   <= 1'b1;
      target_reached <= 1'b0;
      reached_time   <= '0;
      session_over   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.op == OP_ERR) begin
        previous_error <= e_f;
        integral_sum   <= int_clr ? '0 : int_next;
        ramp_level     <= ramp_sum[24] ? 24'hFF_FFFF : ramp_sum[23:0];
        first_sample   <= 1'b0;
      end
      if (commit && !session_over) begin
        if (cond) begin
          target_reached <= 1'b1;
          reached_time   <= rt_new;
        end
        if (ended) session_over <= 1'b1;
      end
      if (commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAKE: begin
        px <= pos_x;
        py <= pos_y;
        hd <= heading;
        t  <= elapsed_us;
        ft <= front_touch;
        bp <= back_pressed;
      end
      OP_DIFF: begin
        dx <= $signed({target_x[23], target_x}) - $signed({px[23], px});
        dy <= $signed({target_y[23], target_y}) - $signed({py[23], py});
      end
      OP_SQX: begin
        radicand <= 50'(dx * dx);
        rem      <= '0;
        root     <= '0;
      end
      OP_SQY: radicand <= radicand + 50'(dy * dy);
      OP_SQRT: begin
        radicand <= {radicand[47:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= 26'(rem_sh - trial);
          root <= {root[23:0], 1'b1};
        end else begin
          rem  <= rem_sh[25:0];
          root <= {root[23:0], 1'b0};
        end
      end
      OP_ERR: begin
        e_reg  <= e_f;
        sv_reg <= sv;
        d_reg  <= d_val;
      end
      OP_MUL_P: acc <= CW'(prod);
      OP_MUL_I, OP_MUL_D: acc <= acc + CW'(prod);
      OP_VOLT: m_reg <= mm;
      OP_HEAD: begin
        hx <= 22'(hd * 6'd34);
        hq <= 33'(hd * 17'd93206);
      end
      OP_VEC_INIT: begin
        h32      <= 32'(hq + 33'((45'(hx) * 45'(H_RECIP)) >> 28));
        zero_vec <= (dx == '0) && (dy == '0);
        if (dx[24]) begin
          cx <= -$signed({{3{dx[24]}}, dx, 28'b0});
          cy <= -$signed({{3{dy[24]}}, dy, 28'b0});
          cz <= $signed(ZW'(32'h8000_0000));
        end else begin
          cx <= $signed({{3{dx[24]}}, dx, 28'b0});
          cy <= $signed({{3{dy[24]}}, dy, 28'b0});
          cz <= '0;
        end
      end
      OP_VEC, OP_ROT: begin
        if (br) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - $signed({2'b00, atan});
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + $signed({2'b00, atan});
        end
      end
      OP_ROT_INIT: begin
        rneg <= fold;
        cz   <= fold ? $signed({{2{~ang[31]}}, ang - 32'h8000_0000})
                     : $signed({{2{ang[31]}}, ang});
        cx   <= $signed({18'b0, 38'(m_reg * GAIN_Q24)});
        cy   <= '0;
      end
      OP_FIN: begin
        if (commit) begin
          if (session_over || ended) begin
            positive_diag_mv <= '0;
            negative_diag_mv <= '0;
          end else begin
            positive_diag_mv <= snv;
            negative_diag_mv <= cv;
          end
          grip_front <= !session_over && gf;
          grip_back  <= !session_over && gb;
          done_res   <= session_over || ended;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/holonomic_drive_to_point_pid.sv -----
// holonomic_drive_to_point_pid: top level of the x-drive drive-to-point pid controller
// depends on hdp_pkg, hdp_if, hdp_ctrl and hdp_dp

// One position sample in, one pair of diagonal motor voltages out. Until the session
// ends, each sample runs through the bit-pair square root of the target distance and
// the vectoring and the rotating passes of the one shared cordic unit, and no new
// sample is taken until it is finished; the three pid products share a single
// multiplier. The next sample is taken while the last result still waits in the
// output register. Once the session has ended a sample goes straight to the finish
// and returns zero volts with done_res. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while idle, the block does not enforce it.
module holonomic_drive_to_point_pid import hdp_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned SETTLE_US    = 250000
) (
  input  logic                  clk,
  input  logic                  rst,
  hdp_in_if.sink                sample,
  hdp_out_if.source             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  hdp_cmd_t  cmd;
  hdp_stat_t stat;

  hdp_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hdp_dp #(.SETTLE_US(SETTLE_US)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pos_x            (sample.pos_x),
    .pos_y            (sample.pos_y),
    .heading          (sample.heading),
    .elapsed_us       (sample.elapsed_us),
    .front_touch      (sample.front_touch),
    .back_pressed     (sample.back_pressed),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .positive_diag_mv (result.positive_diag_mv),
    .negative_diag_mv (result.negative_diag_mv),
    .grip_front       (result.grip_front),
    .grip_back        (result.grip_back),
    .done_res         (result.done_res)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample taken while one is in flight");

  a_grip_ends: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.grip_front || result.grip_back)) |-> result.done_res)
    else $error("grip without session end");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.done_res) |->
      (result.positive_diag_mv == '0 && result.negative_diag_mv == '0))
    else $error("drive voltage after session end");

endmodule
